/* rtl/abg_pkg.sv */
package abg_pkg;

  localparam int COORD_BITS = 16;
  localparam int SCORE_FRAC_BITS = 16;
  localparam int EXT_BITS = COORD_BITS + 1;
  localparam int AREA_BITS = 2 * EXT_BITS;
  localparam int UNI_BITS = AREA_BITS + 1;
  localparam int SCORE_BITS = SCORE_FRAC_BITS + 2;
  localparam int QUO_BITS = SCORE_FRAC_BITS + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [EXT_BITS-1:0] ext_t;
  typedef logic [AREA_BITS-1:0] area_t;
  typedef logic [UNI_BITS-1:0] uni_t;
  typedef logic [QUO_BITS-1:0] quo_t;
  typedef logic [SCORE_BITS-1:0] score_t;

  typedef struct packed {
    uni_t  inter;
    uni_t  uni;
    uni_t  pnum;
    uni_t  enc;
    logic  giou;
  } job_t;

  typedef struct packed {
    score_t score;
    logic   uflag;
    logic   eflag;
  } res_t;

  function automatic ext_t clamp_ext(coord_t lo, coord_t hi);
    logic signed [COORD_BITS:0] d;
    d = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
    clamp_ext = (hi > lo) ? ext_t'(d) : '0;
  endfunction

  function automatic coord_t smin(coord_t a, coord_t b);
    smin = (a < b) ? a : b;
  endfunction

  function automatic coord_t smax(coord_t a, coord_t b);
    smax = (a > b) ? a : b;
  endfunction

endpackage

/* rtl/abg_front.sv */
module abg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  abg_pkg::coord_t al_i,
  input  abg_pkg::coord_t at_i,
  input  abg_pkg::coord_t ar_i,
  input  abg_pkg::coord_t ab_i,
  input  abg_pkg::coord_t bl_i,
  input  abg_pkg::coord_t bt_i,
  input  abg_pkg::coord_t br_i,
  input  abg_pkg::coord_t bb_i,
  input  logic            giou_i,
  output logic            valid_o,
  input  logic            stall_i,
  output abg_pkg::job_t   job_o
);
  import abg_pkg::*;

  logic v1_q, v2_q;
  ext_t awx_q, awy_q, bwx_q, bwy_q, iwx_q, iwy_q, ewx_q, ewy_q;
  logic g1_q;
  area_t aa_q, ba_q, ia_q, ea_q;
  logic g2_q;
  logic adv1, adv2;
  uni_t u;

  assign adv2 = !v2_q || !stall_i;
  assign adv1 = !v1_q || adv2;
  assign stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      awx_q <= clamp_ext(al_i, ar_i);
      awy_q <= clamp_ext(at_i, ab_i);
      bwx_q <= clamp_ext(bl_i, br_i);
      bwy_q <= clamp_ext(bt_i, bb_i);
      iwx_q <= clamp_ext(smax(al_i, bl_i), smin(ar_i, br_i));
      iwy_q <= clamp_ext(smax(at_i, bt_i), smin(ab_i, bb_i));
      ewx_q <= clamp_ext(smin(al_i, bl_i), smax(ar_i, br_i));
      ewy_q <= clamp_ext(smin(at_i, bt_i), smax(ab_i, bb_i));
      g1_q  <= giou_i;
    end
    if (adv2 && v1_q) begin
      aa_q <= awx_q * awy_q;
      ba_q <= bwx_q * bwy_q;
      ia_q <= iwx_q * iwy_q;
      ea_q <= ewx_q * ewy_q;
      g2_q <= g1_q;
    end
  end

  assign u = (UNI_BITS'(aa_q) - UNI_BITS'(ia_q)) + UNI_BITS'(ba_q);

  always_comb begin
    job_o.inter = UNI_BITS'(ia_q);
    job_o.uni   = u;
    job_o.enc   = UNI_BITS'(ea_q);
    job_o.pnum  = (UNI_BITS'(ea_q) >= u) ? UNI_BITS'(ea_q) - u : '0;
    job_o.giou  = g2_q;
  end
  assign valid_o = v2_q;
endmodule

/* rtl/abg_fifo.sv */
module abg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  abg_pkg::job_t data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output abg_pkg::job_t data_o
);
  import abg_pkg::*;

  job_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0] cnt_q;
  logic push, pop;

  assign stall_o = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push = valid_i && !stall_o;
  assign pop = valid_o && !stall_i;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule

/* rtl/abg_back.sv */
module abg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  abg_pkg::job_t job_i,
  output logic          valid_o,
  input  logic          stall_i,
  output abg_pkg::res_t res_o
);
  import abg_pkg::*;

  localparam int NS = SCORE_FRAC_BITS + 1;

  logic  v_q   [NS];
  uni_t  ir_q  [NS];
  uni_t  id_q  [NS];
  quo_t  iq_q  [NS];
  uni_t  pr_q  [NS];
  uni_t  pd_q  [NS];
  quo_t  pq_q  [NS];
  logic  uf_q  [NS];
  logic  ef_q  [NS];
  logic  g_q   [NS];
  logic  vo_q;
  res_t  res_q;
  logic  adv;
  logic  isat, psat;

  assign adv = !(vo_q && stall_i);
  assign stall_o = !adv;
  assign isat = (job_i.inter >= job_i.uni);
  assign psat = (job_i.pnum >= job_i.enc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) v_q[k] <= v_q[k-1];
      vo_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ir_q[0] <= isat ? '0 : job_i.inter;
      id_q[0] <= job_i.uni;
      iq_q[0] <= isat ? quo_t'(1) : '0;
      pr_q[0] <= psat ? '0 : job_i.pnum;
      pd_q[0] <= job_i.enc;
      pq_q[0] <= psat ? quo_t'(1) : '0;
      uf_q[0] <= (job_i.uni == '0);
      ef_q[0] <= job_i.giou && (job_i.enc == '0);
      g_q[0]  <= job_i.giou;
      for (int k = 1; k < NS; k++) begin
        logic [UNI_BITS:0] ti, tp;
        ti = {ir_q[k-1], 1'b0};
        tp = {pr_q[k-1], 1'b0};
        if (ti >= {1'b0, id_q[k-1]}) begin
          ir_q[k] <= UNI_BITS'(ti - {1'b0, id_q[k-1]});
          iq_q[k] <= {iq_q[k-1][QUO_BITS-2:0], 1'b1};
        end else begin
          ir_q[k] <= UNI_BITS'(ti);
          iq_q[k] <= {iq_q[k-1][QUO_BITS-2:0], 1'b0};
        end
        if (tp >= {1'b0, pd_q[k-1]}) begin
          pr_q[k] <= UNI_BITS'(tp - {1'b0, pd_q[k-1]});
          pq_q[k] <= {pq_q[k-1][QUO_BITS-2:0], 1'b1};
        end else begin
          pr_q[k] <= UNI_BITS'(tp);
          pq_q[k] <= {pq_q[k-1][QUO_BITS-2:0], 1'b0};
        end
        id_q[k] <= id_q[k-1];
        pd_q[k] <= pd_q[k-1];
        uf_q[k] <= uf_q[k-1];
        ef_q[k] <= ef_q[k-1];
        g_q[k]  <= g_q[k-1];
      end
      res_q.uflag <= uf_q[NS-1];
      res_q.eflag <= ef_q[NS-1];
      res_q.score <= SCORE_BITS'(
        (uf_q[NS-1] ? SCORE_BITS'(0) : SCORE_BITS'(iq_q[NS-1])) -
        ((!g_q[NS-1] || ef_q[NS-1]) ? SCORE_BITS'(0) : SCORE_BITS'(pq_q[NS-1])));
    end
  end

  assign valid_o = vo_q;
  assign res_o = res_q;
endmodule

/* rtl/aligned_box_giou.sv */
// Path: front extent and area registers, the job queue, then the divider stages and the output register.
// Throughput: one box pair per cycle while out_stall is low; the restoring
// dividers are fully pipelined, one quotient bit per stage.
// Reset: asynchronous, active low; clears all valid flags and the queue,
// and sets the score mode (mode_q) to GIoU.
module aligned_box_giou (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  abg_pkg::coord_t        first_left_i,
  input  abg_pkg::coord_t        first_top_i,
  input  abg_pkg::coord_t        first_right_i,
  input  abg_pkg::coord_t        first_bottom_i,
  input  abg_pkg::coord_t        second_left_i,
  input  abg_pkg::coord_t        second_top_i,
  input  abg_pkg::coord_t        second_right_i,
  input  abg_pkg::coord_t        second_bottom_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [abg_pkg::SCORE_BITS-1:0] overlap_score_o,
  output logic                   union_was_zero_o,
  output logic                   enclosure_was_zero_o
);
  import abg_pkg::*;

  logic mode_q;
  logic fv, fs, qv, qs;
  job_t fj, qj;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b1;
    else if (cfg_valid && cfg_ready) mode_q <= cfg_data;
  end

  abg_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid), .stall_o(in_stall),
    .al_i(first_left_i), .at_i(first_top_i), .ar_i(first_right_i), .ab_i(first_bottom_i),
    .bl_i(second_left_i), .bt_i(second_top_i), .br_i(second_right_i),
    .bb_i(second_bottom_i),
    .giou_i(mode_q),
    .valid_o(fv), .stall_i(fs), .job_o(fj)
  );

  abg_fifo u_fifo (
    .clk_i, .rst_ni,
    .valid_i(fv), .stall_o(fs), .data_i(fj),
    .valid_o(qv), .stall_i(qs), .data_o(qj)
  );

  abg_back u_back (
    .clk_i, .rst_ni,
    .valid_i(qv), .stall_o(qs), .job_i(qj),
    .valid_o(out_valid), .stall_i(out_stall), .res_o(res)
  );

  assign overlap_score_o = res.score;
  assign union_was_zero_o = res.uflag;
  assign enclosure_was_zero_o = res.eflag;

  a_eflag_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && enclosure_was_zero_o |-> union_was_zero_o)
    else $error("enclosure flag without union flag");
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (overlap_score_o <= $signed(SCORE_BITS'(1 << SCORE_FRAC_BITS))))
    else $error("score above one");
  a_fifo_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs |-> qv)
    else $error("queue full yet empty");
endmodule
